// File: hw/rtl/iso_ep_pkg.sv
`default_nettype none

package iso_ep_pkg;

  // Input word: one character of the timestamp string
  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
  } in_word_t;

  // Output word: validity and epoch time in milliseconds
  typedef struct packed {
    logic        valid_res;
    logic [47:0] unix_ms;
  } out_word_t;

  // Parse phases
  typedef enum logic [3:0] {
    PH_YEAR   = 4'd0,
    PH_MONTH  = 4'd1,
    PH_DAY    = 4'd2,
    PH_HOUR   = 4'd3,
    PH_MINUTE = 4'd4,
    PH_SECOND = 4'd5,
    PH_FRAC   = 4'd6,
    PH_DONE   = 4'd7
  } phase_t;

  // Controller states
  typedef enum logic [2:0] {
    S_PARSE,
    S_LEAP,
    S_CHECK,
    S_ERA,
    S_DOE,
    S_DAYS,
    S_SECS,
    S_LOAD
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic step;
    logic leap_en;
    logic chk_en;
    logic era_en;
    logic doe_en;
    logic days_en;
    logic secs_en;
    logic load;
  } ctrl_cmd_t;

  // Characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_Z     = 8'h5A;

  // Range limits
  localparam logic [13:0] YEAR_MIN = 14'd1970;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  // x / 100 == (x * DIV100_MUL) >> DIV100_SH for all 14-bit x
  localparam int          DIV100_W   = 13;
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int          DIV100_SH  = 19;
  localparam int          PROD_W     = 14 + DIV100_W;

  // Calendar constants
  localparam logic [17:0] ERA_DAYS     = 18'd146097;
  localparam logic [21:0] EPOCH_SHIFT  = 22'd719468;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // Saturation bound of each numeric field
  function automatic logic [13:0] field_bound(input phase_t ph);
    logic [13:0] b;
    case (ph)
      PH_YEAR:   b = 14'd9999;
      PH_MONTH:  b = 14'd12;
      PH_DAY:    b = 14'd31;
      PH_HOUR:   b = 14'd23;
      default:   b = 14'd59;
    endcase
    return b;
  endfunction

  // Separator that closes each field before the seconds
  function automatic logic [7:0] field_sep(input phase_t ph);
    logic [7:0] s;
    case (ph)
      PH_YEAR:  s = CH_DASH;
      PH_MONTH: s = CH_DASH;
      PH_DAY:   s = CH_T;
      default:  s = CH_COLON;
    endcase
    return s;
  endfunction

  // Length of a month in a common year
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] l;
    case (m)
      4'd2:    l = 5'd28;
      4'd4:    l = 5'd30;
      4'd6:    l = 5'd30;
      4'd9:    l = 5'd30;
      4'd11:   l = 5'd30;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

  // Days from March 1 to the first of the month, year starting in March
  function automatic logic [8:0] mar_offset(input logic [3:0] m);
    logic [8:0] o;
    case (m)
      4'd3:    o = 9'd0;
      4'd4:    o = 9'd31;
      4'd5:    o = 9'd61;
      4'd6:    o = 9'd92;
      4'd7:    o = 9'd122;
      4'd8:    o = 9'd153;
      4'd9:    o = 9'd184;
      4'd10:   o = 9'd214;
      4'd11:   o = 9'd245;
      4'd12:   o = 9'd275;
      4'd1:    o = 9'd306;
      4'd2:    o = 9'd337;
      default: o = 9'd0;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/iso_ep_ctrl.sv
`default_nettype none

module iso_ep_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_last,
  input  wire logic                  out_stall,
  output logic                       in_stall,
  output logic                       out_valid,
  output iso_ep_pkg::ctrl_cmd_t      cmd
);

  iso_ep_pkg::state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;
  logic               out_free;

  assign accept   = in_valid && (state_r == iso_ep_pkg::S_PARSE);
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      iso_ep_pkg::S_PARSE: if (accept && in_last) state_nxt = iso_ep_pkg::S_LEAP;
      iso_ep_pkg::S_LEAP:  state_nxt = iso_ep_pkg::S_CHECK;
      iso_ep_pkg::S_CHECK: state_nxt = iso_ep_pkg::S_ERA;
      iso_ep_pkg::S_ERA:   state_nxt = iso_ep_pkg::S_DOE;
      iso_ep_pkg::S_DOE:   state_nxt = iso_ep_pkg::S_DAYS;
      iso_ep_pkg::S_DAYS:  state_nxt = iso_ep_pkg::S_SECS;
      iso_ep_pkg::S_SECS:  state_nxt = iso_ep_pkg::S_LOAD;
      iso_ep_pkg::S_LOAD:  if (out_free) state_nxt = iso_ep_pkg::S_PARSE;
      default:             state_nxt = iso_ep_pkg::S_PARSE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    case (state_r)
      iso_ep_pkg::S_PARSE: begin
        in_stall = 1'b0;
        cmd.step = accept;
      end
      iso_ep_pkg::S_LEAP:  cmd.leap_en = 1'b1;
      iso_ep_pkg::S_CHECK: cmd.chk_en  = 1'b1;
      iso_ep_pkg::S_ERA:   cmd.era_en  = 1'b1;
      iso_ep_pkg::S_DOE:   cmd.doe_en  = 1'b1;
      iso_ep_pkg::S_DAYS:  cmd.days_en = 1'b1;
      iso_ep_pkg::S_SECS:  cmd.secs_en = 1'b1;
      iso_ep_pkg::S_LOAD:  cmd.load    = out_free;
      default: ;
    endcase
    out_valid_nxt = cmd.load || (out_valid_r && out_stall);
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= iso_ep_pkg::S_PARSE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/iso_ep_dp.sv
`default_nettype none

module iso_ep_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire iso_ep_pkg::in_word_t  in_word,
  input  wire iso_ep_pkg::ctrl_cmd_t cmd,
  output iso_ep_pkg::out_word_t      out_word
);

  localparam int PROD_W_L = iso_ep_pkg::PROD_W;

  // Parser state
  iso_ep_pkg::phase_t phase_r, phase_nxt;
  logic [13:0] acc_r,    acc_nxt;
  logic [13:0] year_r,   year_nxt;
  logic [3:0]  month_r,  month_nxt;
  logic [4:0]  day_r,    day_nxt;
  logic [4:0]  hour_r,   hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [5:0]  second_r, second_nxt;
  logic [9:0]  milli_r,  milli_nxt;
  logic [1:0]  fcnt_r,   fcnt_nxt;
  logic        seen_r,   seen_nxt;
  logic        err_r,    err_nxt;

  // Conversion registers
  logic [7:0]  qy_r;
  logic        ok_r;
  logic [13:0] yp_r;
  logic [7:0]  q_r;
  logic [17:0] doe_r;
  logic [5:0]  era_r;
  logic [21:0] days_r;
  logic [37:0] secs_r;
  iso_ep_pkg::out_word_t out_r;

  // Character decode
  logic [7:0]  c;
  logic        is_digit;
  logic [7:0]  cdiff;
  logic [3:0]  d;
  logic [16:0] acc_next;
  logic [13:0] bound;

  assign c        = in_word.text_char;
  assign is_digit = (c >= iso_ep_pkg::CH_ZERO) && (c <= iso_ep_pkg::CH_NINE);
  assign cdiff    = c - iso_ep_pkg::CH_ZERO;
  assign d        = cdiff[3:0];
  assign acc_next = 17'(17'(acc_r) * 17'd10) + 17'(d);
  assign bound    = iso_ep_pkg::field_bound(phase_r);

  // Parse one character; cleared after the result is loaded
  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    milli_nxt  = milli_r;
    fcnt_nxt   = fcnt_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    if (cmd.load) begin
      phase_nxt  = iso_ep_pkg::PH_YEAR;
      acc_nxt    = '0;
      year_nxt   = '0;
      month_nxt  = '0;
      day_nxt    = '0;
      hour_nxt   = '0;
      minute_nxt = '0;
      second_nxt = '0;
      milli_nxt  = '0;
      fcnt_nxt   = '0;
      seen_nxt   = 1'b0;
      err_nxt    = 1'b0;
    end else if (cmd.step && !err_r) begin
      case (phase_r)
        iso_ep_pkg::PH_YEAR, iso_ep_pkg::PH_MONTH, iso_ep_pkg::PH_DAY,
        iso_ep_pkg::PH_HOUR, iso_ep_pkg::PH_MINUTE, iso_ep_pkg::PH_SECOND: begin
          if (is_digit) begin
            if (acc_next > 17'(bound)) begin
              acc_nxt = bound;
              err_nxt = 1'b1;
            end else begin
              acc_nxt = acc_next[13:0];
            end
            seen_nxt = 1'b1;
          end else if (!seen_r) begin
            err_nxt = 1'b1;
          end else if ((phase_r != iso_ep_pkg::PH_SECOND) &&
                       (c != iso_ep_pkg::field_sep(phase_r))) begin
            err_nxt = 1'b1;
          end else if ((phase_r == iso_ep_pkg::PH_SECOND) &&
                       (c != iso_ep_pkg::CH_DOT) && (c != iso_ep_pkg::CH_Z)) begin
            err_nxt = 1'b1;
          end else begin
            // field closed: store it and move on
            case (phase_r)
              iso_ep_pkg::PH_YEAR:   year_nxt   = acc_r;
              iso_ep_pkg::PH_MONTH:  month_nxt  = acc_r[3:0];
              iso_ep_pkg::PH_DAY:    day_nxt    = acc_r[4:0];
              iso_ep_pkg::PH_HOUR:   hour_nxt   = acc_r[4:0];
              iso_ep_pkg::PH_MINUTE: minute_nxt = acc_r[5:0];
              default:               second_nxt = acc_r[5:0];
            endcase
            acc_nxt  = '0;
            seen_nxt = 1'b0;
            if (phase_r != iso_ep_pkg::PH_SECOND) begin
              phase_nxt = iso_ep_pkg::phase_t'(phase_r + 4'd1);
            end else if (c == iso_ep_pkg::CH_DOT) begin
              phase_nxt = iso_ep_pkg::PH_FRAC;
            end else begin
              phase_nxt = iso_ep_pkg::PH_DONE;
            end
          end
        end
        iso_ep_pkg::PH_FRAC: begin
          if (is_digit) begin
            if (fcnt_r != 2'd3) begin
              milli_nxt = 10'(milli_r * 10'd10) + 10'(d);
              fcnt_nxt  = fcnt_r + 2'd1;
            end
            seen_nxt = 1'b1;
          end else if ((c == iso_ep_pkg::CH_Z) && seen_r) begin
            // pad to three digits
            case (fcnt_r)
              2'd1:    milli_nxt = 10'(milli_r * 10'd100);
              2'd2:    milli_nxt = 10'(milli_r * 10'd10);
              default: milli_nxt = milli_r;
            endcase
            fcnt_nxt  = 2'd3;
            seen_nxt  = 1'b0;
            phase_nxt = iso_ep_pkg::PH_DONE;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: err_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= iso_ep_pkg::PH_YEAR;
      acc_r    <= '0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      milli_r  <= '0;
      fcnt_r   <= '0;
      seen_r   <= 1'b0;
      err_r    <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      milli_r  <= milli_nxt;
      fcnt_r   <= fcnt_nxt;
      seen_r   <= seen_nxt;
      err_r    <= err_nxt;
    end
  end

  // Leap-year and range check
  logic [PROD_W_L-1:0] qy_prod;
  logic [13:0] ry;
  logic        leap;
  logic [5:0]  lim;
  logic        ok_c;

  assign qy_prod = PROD_W_L'(year_r) * PROD_W_L'(iso_ep_pkg::DIV100_MUL);
  assign ry      = year_r - 14'(qy_r * 14'd100);
  assign leap    = (year_r[1:0] == 2'd0) && ((ry != 14'd0) || (qy_r[1:0] == 2'd0));
  assign lim     = 6'(iso_ep_pkg::month_len(month_r)) +
                   6'((month_r == 4'd2) && leap);
  assign ok_c    = !err_r && (phase_r == iso_ep_pkg::PH_DONE) &&
                   (year_r >= iso_ep_pkg::YEAR_MIN) && (year_r <= iso_ep_pkg::YEAR_MAX) &&
                   (month_r >= 4'd1) && (month_r <= 4'd12) &&
                   (day_r >= 5'd1) && (6'(day_r) <= lim);

  // Era and day of era
  logic [PROD_W_L-1:0] q_prod;
  logic [13:0] rq;
  logic [8:0]  yoe;
  logic [9:0]  doy;
  logic [17:0] doe_c;

  assign q_prod = PROD_W_L'(yp_r) * PROD_W_L'(iso_ep_pkg::DIV100_MUL);
  assign rq     = yp_r - 14'(q_r * 14'd100);
  assign yoe    = 9'(q_r[1:0] * 9'd100) + rq[8:0];
  assign doy    = 10'(iso_ep_pkg::mar_offset(month_r)) + 10'(day_r) - 10'd1;
  assign doe_c  = 18'(yoe * 18'd365) + 18'(yoe[8:2]) - 18'(q_r[1:0]) + 18'(doy);

  // Conversion pipeline, one step per command
  always_ff @(posedge clk) begin
    if (cmd.leap_en) begin
      qy_r <= 8'(qy_prod >> iso_ep_pkg::DIV100_SH);
    end
    if (cmd.chk_en) begin
      ok_r <= ok_c;
      yp_r <= year_r - 14'(month_r <= 4'd2);
    end
    if (cmd.era_en) begin
      q_r <= 8'(q_prod >> iso_ep_pkg::DIV100_SH);
    end
    if (cmd.doe_en) begin
      doe_r <= doe_c;
      era_r <= q_r[7:2];
    end
    if (cmd.days_en) begin
      days_r <= 22'(22'(era_r) * 22'(iso_ep_pkg::ERA_DAYS)) + 22'(doe_r) -
                iso_ep_pkg::EPOCH_SHIFT;
    end
    if (cmd.secs_en) begin
      secs_r <= 38'(38'(days_r) * 38'(iso_ep_pkg::SECS_PER_DAY)) +
                38'(38'(hour_r) * 38'd3600) + 38'(38'(minute_r) * 38'd60) +
                38'(second_r);
    end
    if (cmd.load) begin
      out_r.valid_res <= ok_r;
      out_r.unix_ms   <= ok_r ? (48'(48'(secs_r) * 48'd1000) + 48'(milli_r)) : 48'd0;
    end
  end

  assign out_word = out_r;

endmodule

`default_nettype wire

// File: hw/rtl/iso8601_utc_to_epoch_ms.sv
// Throughput: one character per cycle while parsing; after the last one, in_stall holds
// input off while the date conversion runs and while out_stall holds back the result.
// The conversion runs as a chain of registered steps (leap, check, era, day of era,
// days, seconds, load), some of which hold more than one multiply.
// Reset (rst_n low, synchronous) returns the parser to the start of the year field
// and clears the output valid flag.
`default_nettype none

module iso8601_utc_to_epoch_ms (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire iso_ep_pkg::in_word_t  in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output iso_ep_pkg::out_word_t      out_word
);

  iso_ep_pkg::ctrl_cmd_t cmd;

  // Sequencer
  iso_ep_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_word.is_last),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Parser and conversion datapath
  iso_ep_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .out_word (out_word)
  );

endmodule

`default_nettype wire
